// ===== hw/rtl/bfa_pkg.sv =====
// Shared types and constants for the bitmap first-free allocator.
// No dependencies; imported by bfa_front, bfa_back and the top level.
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int MAP_WORDS_DEF = 256;
  localparam int WORD_BITS     = 32;
  localparam int INDEX_W       = 13;
  localparam int WORD_IDX_W    = 8;    // words reachable by a 13-bit index
  localparam int BIT_POS_W     = 5;
  localparam int REACH_WORDS   = 256;
  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_NONE_FREE = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TEST    = 2'd2,
    CMD_RESERVE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [INDEX_W-1:0] bit_index;
  } in_word_t;

  typedef struct packed {
    logic               status;
    logic [INDEX_W-1:0] granted_index;
    logic               was_set;
  } out_word_t;

  // Classified request as it sits in the queue between front and back.
  typedef struct packed {
    cmd_t                  cmd;
    logic [WORD_IDX_W-1:0] word;
    logic [BIT_POS_W-1:0]  bit_pos;
    logic                  in_range;
  } job_t;

  // Position of the lowest clear bit; zero when the word is full.
  function automatic logic [BIT_POS_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_POS_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bfa_front.sv =====
// Front end: accepts request words, splits and range-checks the index,
// and holds them in a two-entry queue for the back end. Uses bfa_pkg.
`timescale 1ns / 1ps
module bfa_front #(
  parameter int MAP_WORDS = bfa_pkg::MAP_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfa_pkg::in_word_t in_data,
  input  logic              map_clearing,
  output logic              q_valid,
  input  logic              q_pop,
  output bfa_pkg::job_t     q_data
);
  import bfa_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QW     = $clog2(QDEPTH);
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam logic [INDEX_W-1:0] MAP_WORDS_W = INDEX_W'(MAP_WORDS);

  job_t            ent_r [QDEPTH];
  logic [QW-1:0]   wr_ptr_r;
  logic [QW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  job_t            job_in;
  logic            push;
  logic            pop;

  always_comb begin
    job_in.cmd     = in_data.command;
    job_in.word    = in_data.bit_index[INDEX_W-1:BIT_POS_W];
    job_in.bit_pos = in_data.bit_index[BIT_POS_W-1:0];
    // allocate picks its own word later
    job_in.in_range = (in_data.command == CMD_ALLOC) ||
                      ({{(INDEX_W-WORD_IDX_W){1'b0}}, job_in.word} < MAP_WORDS_W);
  end

  assign in_ready = !map_clearing && (count_r != CW'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_data   = ent_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        ent_r[wr_ptr_r] <= job_in;
        wr_ptr_r        <= wr_ptr_r + QW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/bfa_back.sv =====
// Back end: clears the usage map after reset, then runs one read-modify-write
// of the map RAM per request, with a per-word full summary for allocate.
// Uses bfa_pkg and bfa_ram.
`timescale 1ns / 1ps
module bfa_back #(
  parameter int MAP_WORDS = bfa_pkg::MAP_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  bfa_pkg::job_t      q_data,
  output logic               map_clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output bfa_pkg::out_word_t out_data
);
  import bfa_pkg::*;

  localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SCAN_WORDS = (MAP_WORDS < REACH_WORDS) ? MAP_WORDS : REACH_WORDS;
  localparam int GROUPS     = (SCAN_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int GW         = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int NF         = GROUPS * WORD_BITS;
  localparam int FW         = $clog2(NF);
  localparam logic [WORD_IDX_W:0] SCAN_W = (WORD_IDX_W + 1)'(SCAN_WORDS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD
  } state_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [WORD_IDX_W-1:0] word;
    logic [BIT_POS_W-1:0]  bit_pos;
    logic                  act;     // map word is read and may be written
  } exec_t;

  state_t                 state_r;
  logic [AW-1:0]          clr_cnt_r;
  exec_t                  job_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;
  logic [NF-1:0]          full_r;

  logic [NF-1:0]          full_eff;
  logic [GROUPS-1:0]      group_full;
  logic [GW-1:0]          g_sel;
  logic [WORD_BITS-1:0]   grp_flags;
  logic                   alloc_found;
  logic [WORD_IDX_W-1:0]  alloc_word;
  logic [WORD_IDX_W-1:0]  issue_word;
  logic                   issue_act;
  logic [AW+WORD_IDX_W-1:0] issue_ext;
  logic [AW+WORD_IDX_W-1:0] job_ext;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  logic [BIT_POS_W-1:0]   bit_k;
  logic [WORD_BITS-1:0]   bit_mask;
  logic [WORD_BITS-1:0]   new_word;
  logic                   out_free;
  logic                   finish;
  logic                   map_write;
  logic                   in_scan;
  out_word_t              result;

  // Words past the scan window count as full so allocate never lands there.
  always_comb begin
    for (int i = 0; i < NF; i++) begin
      full_eff[i] = (i < SCAN_WORDS) ? full_r[i] : 1'b1;
    end
  end

  // Two-level search: first group with a non-full word, then the word.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_full[g] = &full_eff[g*WORD_BITS +: WORD_BITS];
    end
    g_sel = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (!group_full[g]) begin
        g_sel = GW'(g);
      end
    end
  end

  assign grp_flags   = full_eff[g_sel*WORD_BITS +: WORD_BITS];
  assign alloc_found = ~&group_full;
  assign alloc_word  = WORD_IDX_W'({g_sel, lowest_zero(grp_flags)});

  assign issue_word = (q_data.cmd == CMD_ALLOC) ? alloc_word : q_data.word;
  assign issue_act  = (q_data.cmd == CMD_ALLOC) ? alloc_found : q_data.in_range;
  assign issue_ext  = {{AW{1'b0}}, issue_word};
  assign job_ext    = {{AW{1'b0}}, job_r.word};

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign ram_re    = q_pop && issue_act;
  assign ram_raddr = issue_ext[AW-1:0];

  // Modify step on the registered read word, which the RAM holds while ST_MOD waits.
  assign bit_k    = (job_r.cmd == CMD_ALLOC) ? lowest_zero(ram_rdata) : job_r.bit_pos;
  assign bit_mask = WORD_BITS'(1) << bit_k;
  assign new_word = (job_r.cmd == CMD_RELEASE) ? (ram_rdata & ~bit_mask)
                                               : (ram_rdata | bit_mask);

  assign out_free  = !out_valid_r || out_ready;
  assign finish    = (state_r == ST_MOD) && out_free;
  assign map_write = finish && job_r.act && (job_r.cmd != CMD_TEST);
  assign in_scan   = ({1'b0, job_r.word} < SCAN_W);

  always_comb begin
    result.status        = STATUS_DONE;
    result.granted_index = '0;
    result.was_set       = 1'b0;
    if (job_r.cmd == CMD_ALLOC) begin
      if (job_r.act) begin
        result.granted_index = {job_r.word, bit_k};
      end else begin
        result.status = STATUS_NONE_FREE;
      end
    end else if (job_r.act) begin
      result.was_set = ram_rdata[bit_k];
    end
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      // bit 0 of word 0 comes out of reset reserved
      ram_wdata = (clr_cnt_r == '0) ? WORD_BITS'(1) : '0;
    end else begin
      ram_we    = map_write;
      ram_waddr = job_ext[AW-1:0];
      ram_wdata = new_word;
    end
  end

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      full_r      <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(MAP_WORDS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            job_r.cmd     <= q_data.cmd;
            job_r.word    <= issue_word;
            job_r.bit_pos <= q_data.bit_pos;
            job_r.act     <= issue_act;
            state_r       <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (finish) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (map_write && in_scan) begin
        full_r[job_r.word[FW-1:0]] <= (new_word == FULL_WORD);
      end
    end
  end

  assign map_clearing = (state_r == ST_CLEAR);
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

// ===== hw/rtl/bitmap_first_free_allocator.sv =====
// Bitmap first-free allocator: allocate / release / test / reserve over a usage map.
// A result passes through the front-end queue, the map RAM read and the output register.
// Each request's read-modify-write of the map RAM ends before the back end takes the next.
// A two-entry queue lets requests be taken while the back end or the output stalls.
// Reset: a clearing pass rewrites every map word (bit 0 left reserved);
// in_ready stays low until it is done. Uses bfa_pkg, bfa_front and bfa_back.
`timescale 1ns / 1ps
module bitmap_first_free_allocator #(
  parameter int MAP_WORDS = bfa_pkg::MAP_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bfa_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bfa_pkg::out_word_t out_data
);
  import bfa_pkg::*;

  logic q_valid;
  logic q_pop;
  job_t q_data;
  logic map_clearing;

  bfa_front #(
    .MAP_WORDS (MAP_WORDS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .map_clearing (map_clearing),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_data       (q_data)
  );

  bfa_back #(
    .MAP_WORDS (MAP_WORDS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_data       (q_data),
    .map_clearing (map_clearing),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for bitmap_first_free_allocator: random and directed
// requests checked against a bit-accurate mirror of the usage map.
// Depends on bfa_pkg and the allocator RTL only.
`timescale 1ns / 1ps
module testbench;
  import bfa_pkg::*;

  localparam int MAP_WORDS   = MAP_WORDS_DEF;
  localparam int SCAN_WORDS  = (MAP_WORDS < REACH_WORDS) ? MAP_WORDS : REACH_WORDS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  bitmap_first_free_allocator #(.MAP_WORDS(MAP_WORDS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [WORD_BITS-1:0] usage_mirror [MAP_WORDS];
  in_word_t    request_q [$];
  out_word_t   expected_q [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned grant_count = 0;
  int unsigned none_free_count = 0;
  int unsigned cycle_count = 0;

  // Mirror of the block: applies one request to the map copy, returns the result word.
  function automatic out_word_t apply_request(in_word_t req);
    out_word_t            res;
    int unsigned          wi;
    int unsigned          pos;
    bit                   found;
    res = '0;
    res.status = STATUS_DONE;
    wi = req.bit_index / WORD_BITS;
    pos = req.bit_index % WORD_BITS;
    if (req.command == CMD_ALLOC) begin
      res.status = STATUS_NONE_FREE;
      found = 1'b0;
      for (int j = 0; j < SCAN_WORDS && !found; j++) begin
        if (usage_mirror[j] != FULL_WORD) begin
          for (int k = 0; k < WORD_BITS && !found; k++) begin
            if (!usage_mirror[j][k]) begin
              usage_mirror[j][k] = 1'b1;
              res.granted_index = INDEX_W'(j * WORD_BITS + k);
              res.status = STATUS_DONE;
              found = 1'b1;
            end
          end
        end
      end
    end else if (wi < MAP_WORDS) begin
      res.was_set = usage_mirror[wi][pos];
      if (req.command == CMD_RELEASE) begin
        usage_mirror[wi][pos] = 1'b0;
      end else if (req.command == CMD_RESERVE) begin
        usage_mirror[wi][pos] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void queue_request(cmd_t cmd, int unsigned idx);
    in_word_t w;
    w.command = cmd;
    w.bit_index = INDEX_W'(idx);
    request_q.push_back(w);
  endfunction

  // Mostly low indexes so releases and tests hit bits that allocate has handed out.
  function automatic void queue_random(int unsigned count);
    int unsigned r;
    cmd_t        cmd;
    int unsigned idx;
    for (int unsigned i = 0; i < count; i++) begin
      r = $urandom_range(99);
      cmd = (r < 35) ? CMD_ALLOC : (r < 60) ? CMD_RELEASE : (r < 80) ? CMD_TEST : CMD_RESERVE;
      if ($urandom_range(3) == 0) begin
        idx = $urandom_range((1 << INDEX_W) - 1);
      end else begin
        idx = $urandom_range(511);
      end
      queue_request(cmd, idx);
    end
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (request_q.size() != 0 || in_valid || expected_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: holds a word until it is taken, then maybe idles before the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on input handshakes first, then checks output handshakes.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (in_valid && in_ready) begin
        expected_q.push_back(apply_request(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result word: status=%0d granted=%0d was_set=%0d",
                     out_data.status, out_data.granted_index, out_data.was_set);
          end
        end else begin
          automatic out_word_t exp_word = expected_q.pop_front();
          checked_count++;
          if (exp_word.status == STATUS_NONE_FREE) begin
            none_free_count++;
          end else if (exp_word.granted_index != 0 || exp_word.was_set == 1'b0) begin
            grant_count += (out_data.status == STATUS_DONE && exp_word.granted_index != 0);
          end
          if (out_data.status !== exp_word.status ||
              out_data.granted_index !== exp_word.granted_index ||
              out_data.was_set !== exp_word.was_set) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display({"result %0d mismatch: expected status=%0d granted=%0d ",
                        "was_set=%0d, got status=%0d granted=%0d was_set=%0d"},
                       checked_count, exp_word.status, exp_word.granted_index,
                       exp_word.was_set, out_data.status, out_data.granted_index,
                       out_data.was_set);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int j = 0; j < MAP_WORDS; j++) begin
      usage_mirror[j] = '0;
    end
    usage_mirror[0][0] = 1'b1;
    send_idle_pct = 19;
    recv_idle_pct = 68;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bit 0 reserved at reset, edges of the index, redundant writes,
    // releasing bit zero and granting it again
    queue_request(CMD_TEST, 0);
    queue_request(CMD_ALLOC, 0);
    queue_request(CMD_ALLOC, 8191);
    queue_request(CMD_TEST, 8191);
    queue_request(CMD_RESERVE, 8191);
    queue_request(CMD_TEST, 8191);
    queue_request(CMD_RESERVE, 8191);
    queue_request(CMD_RELEASE, 8191);
    queue_request(CMD_RELEASE, 8191);
    queue_request(CMD_RELEASE, 0);
    queue_request(CMD_TEST, 0);
    queue_request(CMD_ALLOC, 0);
    queue_request(CMD_RESERVE, 'h1555);
    queue_request(CMD_TEST, 'h0AAA);
    queue_request(CMD_TEST, 'h1555);
    queue_request(CMD_RESERVE, 31);
    queue_request(CMD_RESERVE, 32);
    queue_request(CMD_RELEASE, 2);
    queue_request(CMD_ALLOC, 'h1FFF);
    queue_request(CMD_ALLOC, 0);
    queue_request(CMD_TEST, 32);
    queue_random(130);
    wait_drained();  // sender holds off until all results are back
    queue_random(130);
    wait_drained();

    send_idle_pct = 68;
    recv_idle_pct = 19;
    queue_random(270);
    wait_drained();

    // allocate burst at full rate across word boundaries, then free a few and reclaim
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 40; i++) begin
      queue_request(CMD_ALLOC, $urandom_range(8191));
    end
    queue_request(CMD_TEST, 8191);
    queue_request(CMD_RELEASE, 5000);
    queue_request(CMD_RELEASE, 100);
    queue_request(CMD_RELEASE, 8191);
    for (int i = 0; i < 4; i++) begin
      queue_request(CMD_ALLOC, 0);
    end
    queue_random(200);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d result words, %0d with a nonzero grant, %0d allocations refused",
             checked_count, grant_count, none_free_count);
    $display("idle mixes: sender/receiver 19/68, 68/19 and none, with a full-rate alloc burst");
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
